@@ sv/usbl_fsa_pkg.sv @@
// ----------------------------------------------------------------------------
// USBL fix set assembler package
// Shared widths, slot indexes, fix kinds and the transaction structs.
// ----------------------------------------------------------------------------
package usbl_fsa_pkg;

  // Slot bookkeeping
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_SELF_RANGE  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_SELF_ANGLES = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DOCK_RANGE  = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_DOCK_ANGLES = 2'd3;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int RANGE_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int WINDOW_W = 16;
  localparam int KIND_W   = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd450;

  // Bus widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 144;

  // Fix kinds; the remaining codes carry nothing
  typedef enum logic [KIND_W-1:0] {
    KIND_RANGE  = 2'd0,
    KIND_ANGLES = 2'd1
  } fix_kind_e;

  // One incoming partial fix
  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic                      from_self;
    fix_kind_e                 fix_kind;
    logic [RANGE_W-1:0]        range_mm;
    logic signed [ANGLE_W-1:0] bearing;
    logic signed [ANGLE_W-1:0] elevation;
  } fix_t;

  // One complete fix set
  typedef struct packed {
    logic [RANGE_W-1:0]        self_range_mm;
    logic signed [ANGLE_W-1:0] self_bearing;
    logic signed [ANGLE_W-1:0] self_elevation;
    logic [RANGE_W-1:0]        dock_range_mm;
    logic signed [ANGLE_W-1:0] dock_bearing;
    logic signed [ANGLE_W-1:0] dock_elevation;
    logic [TIME_W-1:0]         set_time_ms;
  } fix_set_t;

  // Status from the slot core
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slot_valid;
    logic                 emit;
  } core_stat_t;

endpackage

@@ sv/usbl_fsa_in_stage.sv @@
// ----------------------------------------------------------------------------
// USBL fix input stage
// Registers one incoming fix; refills in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module usbl_fsa_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  usbl_fsa_pkg::fix_t  in_fix_i,
  input  logic                advance_i,
  output logic                fix_valid_o,
  output usbl_fsa_pkg::fix_t  fix_o
);
  import usbl_fsa_pkg::*;

  logic fix_valid_q, fix_valid_d;
  fix_t fix_q;
  logic accept;

  // Take a new transaction when empty or when the held fix moves on
  assign in_ready_o = !fix_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    fix_valid_d = fix_valid_q;
    if (accept) begin
      fix_valid_d = 1'b1;
    end else if (advance_i) begin
      fix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_valid_q <= 1'b0;
    end else begin
      fix_valid_q <= fix_valid_d;
    end
  end

  // Payload holds until the next accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fix_q <= in_fix_i;
    end
  end

  assign fix_valid_o = fix_valid_q;
  assign fix_o       = fix_q;

endmodule

@@ sv/usbl_fsa_core.sv @@
// ----------------------------------------------------------------------------
// USBL fix slot core
// Holds the four slots, evicts stale ones, stores each fix of a known kind and decides
// whether a complete set goes out.
// ----------------------------------------------------------------------------
module usbl_fsa_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [usbl_fsa_pkg::WINDOW_W-1:0]      cfg_wdata_i,
  input  logic                                   proc_i,
  input  usbl_fsa_pkg::fix_t                     fix_i,
  output logic                                   emit_o,
  output usbl_fsa_pkg::fix_set_t                 set_o,
  output usbl_fsa_pkg::core_stat_t               stat_o
);
  import usbl_fsa_pkg::*;

  logic [WINDOW_W-1:0]  window_q;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [TIME_W-1:0]    time_q [NUM_SLOTS];
  logic [TIME_W-1:0]    time_d [NUM_SLOTS];
  logic [RANGE_W-1:0]   self_range_q, self_range_d;
  logic [RANGE_W-1:0]   dock_range_q, dock_range_d;
  logic [2*ANGLE_W-1:0] self_angles_q, self_angles_d;
  logic [2*ANGLE_W-1:0] dock_angles_q, dock_angles_d;

  logic                 known;
  logic [SLOT_W-1:0]    slot;
  logic [NUM_SLOTS-1:0] valid_ev, valid_st;
  logic [TIME_W-1:0]    age [NUM_SLOTS];
  logic [TIME_W-1:0]    age_max, age_min;
  logic [SLOT_W-1:0]    i_old, i_new;
  logic                 full, span_bad, emit;

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // Decode the kind and pick the slot
  always_comb begin
    case (fix_i.fix_kind)
      KIND_RANGE, KIND_ANGLES: known = 1'b1;
      default:                 known = 1'b0;
    endcase
    slot = {!fix_i.from_self, fix_i.fix_kind[0]};
  end

  // Evict stale slots, then store the new part
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      valid_ev[i] = valid_q[i] && !((fix_i.now_ms - time_q[i]) > TIME_W'(window_q));
      time_d[i]   = (known && slot == SLOT_W'(i)) ? fix_i.now_ms : time_q[i];
      valid_st[i] = valid_ev[i] || (known && slot == SLOT_W'(i));
      age[i]      = fix_i.now_ms - time_d[i];
    end
  end

  // Update held values
  always_comb begin
    self_range_d  = self_range_q;
    dock_range_d  = dock_range_q;
    self_angles_d = self_angles_q;
    dock_angles_d = dock_angles_q;
    if (known) begin
      case (slot)
        SLOT_SELF_RANGE:  self_range_d  = fix_i.range_mm;
        SLOT_SELF_ANGLES: self_angles_d = {fix_i.bearing, fix_i.elevation};
        SLOT_DOCK_RANGE:  dock_range_d  = fix_i.range_mm;
        SLOT_DOCK_ANGLES: dock_angles_d = {fix_i.bearing, fix_i.elevation};
        default:          self_range_d  = self_range_q;
      endcase
    end
  end

  // Oldest and latest slot; the lowest index wins ties
  always_comb begin
    age_max = age[0];
    i_old   = SLOT_SELF_RANGE;
    age_min = '1;
    i_new   = SLOT_SELF_RANGE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i != 0 && age[i] > age_max) begin
        age_max = age[i];
        i_old   = SLOT_W'(i);
      end
      if (age[i] < age_min) begin
        age_min = age[i];
        i_new   = SLOT_W'(i);
      end
    end
  end

  // Decide on emit and the next valid bits
  always_comb begin
    full     = known && (valid_st == '1);
    span_bad = (age_max - age_min) > TIME_W'(window_q);
    emit     = full && !span_bad;
    if (!known) begin
      valid_d = valid_ev;
    end else if (!full) begin
      valid_d = valid_st;
    end else if (span_bad) begin
      valid_d = valid_st & ~(NUM_SLOTS'(1) << i_old);
    end else begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (proc_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        time_q[i] <= time_d[i];
      end
      self_range_q  <= self_range_d;
      dock_range_q  <= dock_range_d;
      self_angles_q <= self_angles_d;
      dock_angles_q <= dock_angles_d;
    end
  end

  // Assemble the set from the updated values
  always_comb begin
    set_o.self_range_mm  = self_range_d;
    set_o.self_bearing   = self_angles_d[2*ANGLE_W-1:ANGLE_W];
    set_o.self_elevation = self_angles_d[ANGLE_W-1:0];
    set_o.dock_range_mm  = dock_range_d;
    set_o.dock_bearing   = dock_angles_d[2*ANGLE_W-1:ANGLE_W];
    set_o.dock_elevation = dock_angles_d[ANGLE_W-1:0];
    set_o.set_time_ms    = time_d[i_new];
  end

  assign emit_o            = emit;
  assign stat_o.slot_valid = valid_q;
  assign stat_o.emit       = emit;

endmodule

@@ sv/usbl_fsa_out_stage.sv @@
// ----------------------------------------------------------------------------
// USBL fix set output stage
// Result register that holds a set until the downstream takes it.
// ----------------------------------------------------------------------------
module usbl_fsa_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       proc_i,
  input  logic                       emit_i,
  input  usbl_fsa_pkg::fix_set_t     set_i,
  output logic                       advance_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output usbl_fsa_pkg::fix_set_t     set_o
);
  import usbl_fsa_pkg::*;

  logic     out_valid_q, out_valid_d;
  fix_set_t set_q;
  logic     load;

  // The pipeline moves when the result register is free or being drained
  assign advance_o = !out_valid_q || out_ready_i;
  assign load      = proc_i && emit_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      set_q <= set_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign set_o       = set_q;

endmodule

@@ sv/usbl_fix_set_assembler_top.sv @@
// A fix accepted into the input register passes the slot core into the result register when the result side moves.
// Throughput: one fix per cycle while the result side is not stalled; the slot update is a single registered pass.
// The input and result registers each hold one transaction; a stalled result
// still lets one more fix enter.
// Reset clears all slot valid bits, both stage valids and sets the window to 450 ms.
// ----------------------------------------------------------------------------
// USBL fix set assembler top
// Collects own and dock range and angle fixes into time-aligned sets.
// ----------------------------------------------------------------------------
module usbl_fix_set_assembler_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration: window_ms
  input  logic                                    cfg_we_i,
  input  logic [usbl_fsa_pkg::WINDOW_W-1:0]       cfg_wdata_i,
  // Fix input
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // now_ms[31:0], range_mm[55:32], bearing[71:56], elevation[87:72]
  input  logic [usbl_fsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // from_self[0], fix_kind[2:1]
  input  logic [usbl_fsa_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // Fix set output
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // self_range_mm[23:0], self_bearing[39:24], self_elevation[55:40],
  // dock_range_mm[79:56], dock_bearing[95:80], dock_elevation[111:96],
  // set_time_ms[143:112]
  output logic [usbl_fsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import usbl_fsa_pkg::*;

  fix_t       in_fix, fix;
  fix_set_t   set_c, set_q;
  core_stat_t stat;
  logic       fix_valid, advance, proc, emit;

  // Unpack the input transaction
  always_comb begin
    in_fix.now_ms    = s_axis_tdata[31:0];
    in_fix.range_mm  = s_axis_tdata[55:32];
    in_fix.bearing   = s_axis_tdata[71:56];
    in_fix.elevation = s_axis_tdata[87:72];
    in_fix.from_self = s_axis_tuser[0];
    in_fix.fix_kind  = fix_kind_e'(s_axis_tuser[2:1]);
  end

  usbl_fsa_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_fix_i    (in_fix),
    .advance_i   (advance),
    .fix_valid_o (fix_valid),
    .fix_o       (fix)
  );

  assign proc = fix_valid && advance;

  usbl_fsa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .proc_i      (proc),
    .fix_i       (fix),
    .emit_o      (emit),
    .set_o       (set_c),
    .stat_o      (stat)
  );

  usbl_fsa_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .emit_i      (emit),
    .set_i       (set_c),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .set_o       (set_q)
  );

  // Pack the output transaction
  assign m_axis_tdata = {set_q.set_time_ms, set_q.dock_elevation, set_q.dock_bearing,
                         set_q.dock_range_mm, set_q.self_elevation, set_q.self_bearing,
                         set_q.self_range_mm};

`ifndef ASSERT_OFF
  // An emitted set leaves every slot empty
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && stat.emit) |=> (stat.slot_valid == '0))
    else $error("slots not cleared after set emit");

  // A new result only appears after an emitting fix was processed
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(proc && emit))
    else $error("result appeared without an emitting fix");

  // Backpressure only when both registers hold a transaction
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (fix_valid && m_axis_tvalid))
    else $error("input stalled with a free register");

  // A held fix is not dropped while the result side stalls
  a_fix_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fix_valid && !advance) |=> fix_valid)
    else $error("stalled fix dropped");
`endif

endmodule

@@ tb/sv/fix_set_checker.sv @@
// ----------------------------------------------------------------------------
// USBL fix set checker
// Watches the fix and fix set streams and the window register write port.
// It keeps its own copy of the slot state, works out the fix set that each
// accepted fix completes, and compares every emitted set field by field with
// the oldest set still awaited.
// ----------------------------------------------------------------------------
module fix_set_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [usbl_fsa_pkg::WINDOW_W-1:0]    cfg_wdata_i,
  input  logic                                 fix_valid_i,
  input  logic                                 fix_ready_i,
  input  logic [usbl_fsa_pkg::IN_TDATA_W-1:0]  fix_data_i,
  input  logic [usbl_fsa_pkg::IN_TUSER_W-1:0]  fix_user_i,
  input  logic                                 set_valid_i,
  input  logic                                 set_ready_i,
  input  logic [usbl_fsa_pkg::OUT_TDATA_W-1:0] set_data_i,
  output int                                   pending_sets_o,
  output int                                   mismatches_o
);
  import usbl_fsa_pkg::*;

  // Shadow copy of the assembler state
  logic [WINDOW_W-1:0]  window_ms;
  logic [NUM_SLOTS-1:0] slot_vld;
  logic [TIME_W-1:0]    slot_ts [NUM_SLOTS];
  logic [RANGE_W-1:0]   self_rng, dock_rng;
  logic [ANGLE_W-1:0]   self_brg, self_elv, dock_brg, dock_elv;

  fix_set_t awaited_sets [$];
  int       n_mismatch = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] fix set mismatch: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // Apply one accepted fix to the shadow slots; queue a set when one completes
  function automatic void assemble_fix(input logic [IN_TDATA_W-1:0] d,
                                       input logic [IN_TUSER_W-1:0] u);
    fix_t               f;
    fix_set_t           s;
    logic [TIME_W-1:0]  age, age_old, age_new;
    logic [SLOT_W-1:0]  slot;
    int                 i_old, i_new;

    f.now_ms    = d[31:0];
    f.range_mm  = d[55:32];
    f.bearing   = d[71:56];
    f.elevation = d[87:72];
    f.from_self = u[0];
    f.fix_kind  = fix_kind_e'(u[2:1]);

    // Drop slots older than the window
    for (int i = 0; i < NUM_SLOTS; i++) begin
      age = f.now_ms - slot_ts[i];
      if (slot_vld[i] && age > window_ms) slot_vld[i] = 1'b0;
    end

    // Unknown kinds only evict
    if (f.fix_kind != KIND_RANGE && f.fix_kind != KIND_ANGLES) return;

    if (f.from_self) begin
      if (f.fix_kind == KIND_RANGE) begin
        self_rng = f.range_mm;
        slot     = SLOT_SELF_RANGE;
      end else begin
        self_brg = f.bearing;
        self_elv = f.elevation;
        slot     = SLOT_SELF_ANGLES;
      end
    end else begin
      if (f.fix_kind == KIND_RANGE) begin
        dock_rng = f.range_mm;
        slot     = SLOT_DOCK_RANGE;
      end else begin
        dock_brg = f.bearing;
        dock_elv = f.elevation;
        slot     = SLOT_DOCK_ANGLES;
      end
    end
    slot_vld[slot] = 1'b1;
    slot_ts[slot]  = f.now_ms;

    if (slot_vld != '1) return;

    // Oldest slot: first on ties; newest slot: first on ties
    age_old = '0;
    age_new = '1;
    i_old   = 0;
    i_new   = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      age = f.now_ms - slot_ts[i];
      if (i == 0 || age > age_old) begin
        age_old = age;
        i_old   = i;
      end
      if (age < age_new) begin
        age_new = age;
        i_new   = i;
      end
    end

    if (TIME_W'(age_old - age_new) > window_ms) begin
      slot_vld[i_old] = 1'b0;
      return;
    end

    s.self_range_mm  = self_rng;
    s.self_bearing   = self_brg;
    s.self_elevation = self_elv;
    s.dock_range_mm  = dock_rng;
    s.dock_bearing   = dock_brg;
    s.dock_elevation = dock_elv;
    s.set_time_ms    = slot_ts[i_new];
    awaited_sets.push_back(s);
    slot_vld = '0;
  endfunction

  // Compare one emitted set with the oldest awaited one; angles compare as raw bits
  task automatic compare_set(input logic [OUT_TDATA_W-1:0] d);
    fix_set_t want;
    if (awaited_sets.size() == 0) begin
      report_mismatch($sformatf("set %h emitted while none is awaited", d));
      return;
    end
    want = awaited_sets.pop_front();
    check_field("self_range_mm",  d[23:0],    want.self_range_mm);
    check_field("self_bearing",   d[39:24],   $unsigned(want.self_bearing));
    check_field("self_elevation", d[55:40],   $unsigned(want.self_elevation));
    check_field("dock_range_mm",  d[79:56],   want.dock_range_mm);
    check_field("dock_bearing",   d[95:80],   $unsigned(want.dock_bearing));
    check_field("dock_elevation", d[111:96],  $unsigned(want.dock_elevation));
    check_field("set_time_ms",    d[143:112], want.set_time_ms);
  endtask

  // Track transactions on both channels and the window register
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms = WINDOW_RESET;
      slot_vld  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_ts[i] = '0;
      self_rng  = '0;
      dock_rng  = '0;
      self_brg  = '0;
      self_elv  = '0;
      dock_brg  = '0;
      dock_elv  = '0;
      awaited_sets.delete();
      pending_sets_o <= 0;
    end else begin
      if (set_valid_i && set_ready_i) compare_set(set_data_i);
      if (cfg_we_i) window_ms = cfg_wdata_i;
      if (fix_valid_i && fix_ready_i) assemble_fix(fix_data_i, fix_user_i);
      pending_sets_o <= awaited_sets.size();
      mismatches_o   <= n_mismatch;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// USBL fix set assembler testbench
// Drives partial fixes into the assembler: a directed opening on field
// extremes, unknown kinds, wrapped times, ties and window edges, then random
// sets and noise under several window settings, with random idle and stall
// on both channels. The checker beside the block judges every set.
// ----------------------------------------------------------------------------
module tb;
  import usbl_fsa_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 600000;

  // Fix kind codes that carry nothing
  localparam logic [KIND_W-1:0] KIND_VOID_LO = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VOID_HI = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [WINDOW_W-1:0]    cfg_wdata  = '0;
  logic                   fix_valid  = 1'b0;
  logic [IN_TDATA_W-1:0]  fix_data   = '0;
  logic [IN_TUSER_W-1:0]  fix_user   = '0;
  logic                   set_ready  = 1'b0;
  logic                   fix_ready;
  logic                   set_valid;
  logic [OUT_TDATA_W-1:0] set_data;

  int                     pending_sets;
  int                     mismatches;
  int                     cycles = 0;
  bit                     steady_src = 1'b0;
  logic [TIME_W-1:0]      clock_ms = '0;
  logic [WINDOW_W-1:0]    cur_window = WINDOW_RESET;

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  usbl_fix_set_assembler_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (fix_valid),
    .s_axis_tready (fix_ready),
    .s_axis_tdata  (fix_data),
    .s_axis_tuser  (fix_user),
    .m_axis_tvalid (set_valid),
    .m_axis_tready (set_ready),
    .m_axis_tdata  (set_data)
  );

  fix_set_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fix_valid_i    (fix_valid),
    .fix_ready_i    (fix_ready),
    .fix_data_i     (fix_data),
    .fix_user_i     (fix_user),
    .set_valid_i    (set_valid),
    .set_ready_i    (set_ready),
    .set_data_i     (set_data),
    .pending_sets_o (pending_sets),
    .mismatches_o   (mismatches)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one fix and hold it until the transaction completes
  task automatic send_fix(input logic [TIME_W-1:0] now, input logic self,
                          input logic [KIND_W-1:0] kind, input logic [RANGE_W-1:0] rng,
                          input logic [ANGLE_W-1:0] brg, input logic [ANGLE_W-1:0] elv);
    int gap;
    fix_valid <= 1'b1;
    fix_data  <= {elv, brg, rng, now};
    fix_user  <= {kind, self};
    do @(posedge clk); while (!fix_ready);
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      fix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the part that fills one slot, with random content
  task automatic send_part(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] now);
    logic [RANGE_W-1:0] rng;
    logic               self;
    logic [KIND_W-1:0]  kind;
    int                 r;
    r    = $urandom_range(0, 9);
    rng  = (r == 0) ? '0 : (r == 1) ? '1 : RANGE_W'($urandom());
    self = (slot == SLOT_SELF_RANGE || slot == SLOT_SELF_ANGLES);
    kind = (slot == SLOT_SELF_RANGE || slot == SLOT_DOCK_RANGE) ? KIND_RANGE : KIND_ANGLES;
    send_fix(now, self, kind, rng, ANGLE_W'($urandom()), ANGLE_W'($urandom()));
  endtask

  // Wait until every awaited set is out and the pipeline is empty
  task automatic drain_sets();
    fix_valid <= 1'b0;
    do @(posedge clk); while (pending_sets != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] w);
    drain_sets();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_window  = w;
  endtask

  // Random sets, broken sequences and noise; n_items counts known kinds only
  task automatic run_random(input int n_items);
    logic [SLOT_W-1:0] order [NUM_SLOTS];
    logic [SLOT_W-1:0] tmp;
    logic [KIND_W-1:0] kind;
    int                sent, r, w, step, n_parts, k;
    sent = 0;
    w    = cur_window;
    while (sent < n_items) begin
      r          = $urandom_range(0, 99);
      clock_ms  += $urandom_range(1, 50);
      steady_src = ($urandom_range(0, 7) == 0);
      for (int j = 0; j < NUM_SLOTS; j++) order[j] = SLOT_W'(j);
      for (int j = NUM_SLOTS - 1; j > 0; j--) begin
        k        = $urandom_range(0, j);
        tmp      = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
      if (r < 70) begin
        // Full set, now and then stretched past the window
        for (int j = 0; j < NUM_SLOTS; j++) begin
          step = ($urandom_range(0, 9) == 0) ? w / 2 + $urandom_range(1, 64)
                                             : $urandom_range(0, w / 4);
          if (j > 0) clock_ms += step;
          send_part(order[j], clock_ms);
          sent++;
          if ($urandom_range(0, 9) == 0) begin
            send_part(order[j], clock_ms);
            sent++;
          end
        end
      end else if (r < 85) begin
        // Partial set, then a jump that ages it out
        n_parts = $urandom_range(1, 3);
        for (int j = 0; j < n_parts; j++) begin
          send_part(order[j], clock_ms);
          clock_ms += $urandom_range(0, w / 4);
          sent++;
        end
        clock_ms += w + $urandom_range(1, 1000);
      end else begin
        // Noise: any kind at the running time or at any time at all
        kind = KIND_W'($urandom_range(0, 3));
        send_fix($urandom_range(0, 1) ? TIME_W'($urandom()) : clock_ms,
                 1'($urandom_range(0, 1)), kind, RANGE_W'($urandom()),
                 ANGLE_W'($urandom()), ANGLE_W'($urandom()));
        if (kind == KIND_RANGE || kind == KIND_ANGLES) sent++;
      end
    end
    steady_src = 1'b0;
  endtask

  // Result side: ready in runs, stalls of random length, long open stretches
  initial begin : ready_gen
    int hold, stall;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 4);
      set_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        set_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, all four parts at one time
    send_fix(32'd100, 1'b1, KIND_RANGE,  24'hFFFFFF, 16'h8000, 16'h7FFF);
    send_fix(32'd100, 1'b1, KIND_ANGLES, 24'h000000, 16'h8000, 16'h7FFF);
    send_fix(32'd100, 1'b0, KIND_RANGE,  24'h000000, 16'h7FFF, 16'h8000);
    send_fix(32'd100, 1'b0, KIND_ANGLES, 24'hFFFFFF, 16'h7FFF, 16'h8000);
    // Unknown kinds at both time extremes
    send_fix(32'h0000_0000, 1'b0, KIND_VOID_LO, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_fix(32'hFFFF_FFFF, 1'b1, KIND_VOID_HI, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    // Set that straddles the time wrap
    send_part(SLOT_DOCK_ANGLES, 32'hFFFF_FF00);
    send_part(SLOT_SELF_RANGE,  32'hFFFF_FF80);
    send_part(SLOT_DOCK_RANGE,  32'h0000_0010);
    send_part(SLOT_SELF_ANGLES, 32'h0000_0040);
    // Stale parts evicted before the set completes
    send_part(SLOT_SELF_RANGE,  32'd1000);
    send_part(SLOT_DOCK_RANGE,  32'd1200);
    send_part(SLOT_SELF_ANGLES, 32'd1700);
    send_part(SLOT_DOCK_ANGLES, 32'd1700);
    send_part(SLOT_SELF_RANGE,  32'd1800);
    send_part(SLOT_DOCK_RANGE,  32'd1800);
    // Age exactly at the window stays, one past it goes
    send_part(SLOT_SELF_RANGE,  32'd5000);
    send_part(SLOT_SELF_ANGLES, 32'd5000);
    send_part(SLOT_DOCK_RANGE,  32'd5000);
    send_part(SLOT_DOCK_ANGLES, 32'd5450);
    send_part(SLOT_SELF_RANGE,  32'd6000);
    send_part(SLOT_SELF_ANGLES, 32'd6000);
    send_part(SLOT_DOCK_RANGE,  32'd6000);
    send_part(SLOT_DOCK_ANGLES, 32'd6451);
    send_fix(32'd6452, 1'b0, KIND_VOID_HI, 24'h0, 16'h0, 16'h0);

    // Random phases over several windows, two of them started just below the time wrap
    clock_ms = $urandom();
    run_random(150);
    write_window(16'd0);
    run_random(150);
    write_window(16'hFFFF);
    run_random(150);
    write_window(16'd1);
    clock_ms = 32'hFFFF_FF00;
    run_random(150);
    write_window(WINDOW_W'($urandom()));
    clock_ms = 32'hFFFF_0000;
    run_random(150);
    write_window(WINDOW_RESET);
    run_random(150);

    drain_sets();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/usbl_fsa_pkg.sv
sv/usbl_fsa_in_stage.sv
sv/usbl_fsa_core.sv
sv/usbl_fsa_out_stage.sv
sv/usbl_fix_set_assembler_top.sv
tb/sv/fix_set_checker.sv
tb/sv/tb.sv
